// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the port-level checker of the frame-difference motion detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FDMD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define FDMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/fdmd_pkg.sv -----
// Types and constants shared by the frame-difference motion detector modules.
`default_nettype none

package fdmd_pkg;

	localparam int PIX_W          = 8;
	localparam int FRAME_PIXELS_W = 22;
	localparam int THRESH_W       = 16;
	localparam int MEAN_W         = 15;
	localparam int CHANGE_W       = 16;
	localparam int CFG_IDX_W      = 8;
	localparam int CFG_DATA_W     = FRAME_PIXELS_W;
	localparam int QUOT_BITS      = 15;
	localparam int CNT_W          = $clog2(QUOT_BITS);

	localparam logic [CFG_IDX_W-1:0]      CFG_FRAME_PIXELS     = 8'd0;
	localparam logic [CFG_IDX_W-1:0]      CFG_MOTION_THRESHOLD = 8'd1;
	localparam logic [FRAME_PIXELS_W-1:0] FRAME_PIXELS_RST     = 22'd2073600;
	localparam logic [THRESH_W-1:0]       THRESHOLD_RST        = 16'd5;
	localparam logic [MEAN_W-1:0]         MEAN_MAX             = 15'd25500;
	localparam logic [CNT_W-1:0]          DIV_START            = CNT_W'(QUOT_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic update;
		logic mul;
		logic div_step;
		logic finish;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/fdmd_ctrl.sv -----
// Controller state machine of the frame-difference motion detector.
`default_nettype none

module fdmd_ctrl import fdmd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_stall
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				cmd.update = 1'b1;
				state_nxt  = sts.last ? ST_MUL : ST_OUT;
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_nxt  = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/fdmd_dp.sv -----
// Datapath of the frame-difference motion detector: frame store, sum, divider, output register.
`default_nettype none

module fdmd_dp import fdmd_pkg::*; #(
	parameter int MAX_PIXELS = 2097152
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output sts_t                       sts,
	input  logic [PIX_W-1:0]           pixel,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic [PIX_W-1:0]           diff_pixel,
	output logic                       frame_end,
	output logic                       motion,
	output logic signed [CHANGE_W-1:0] mean_change,
	output logic [MEAN_W-1:0]          mean_hundredths
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW = $clog2(MAX_PIXELS + 1);
	localparam int SW = CW + PIX_W;
	localparam int DW = CW + QUOT_BITS;
	localparam int EW = (CW > FRAME_PIXELS_W) ? CW : FRAME_PIXELS_W;

	// Configuration registers
	logic [FRAME_PIXELS_W-1:0] frame_pixels_q;
	logic [THRESH_W-1:0]       threshold_q;

	// Frame store and its fill count; entries at or past the fill count read as zero
	logic [PIX_W-1:0] mem [MAX_PIXELS];
	logic [PIX_W-1:0] rd_q;
	logic [CW-1:0]    fill_q;

	logic [AW-1:0]     pos_q;
	logic [PIX_W-1:0]  pix_q;
	logic [SW-1:0]     sum_q;
	logic [MEAN_W-1:0] prev_mean_q;

	// Working result registers
	logic [PIX_W-1:0]           diff_q;
	logic                       last_q;
	logic [MEAN_W-1:0]          mean_q;
	logic signed [CHANGE_W-1:0] change_q;
	logic                       motion_q;

	// Divider
	logic [DW-1:0]        rem_q;
	logic [DW-1:0]        dsr_q;
	logic [QUOT_BITS-1:0] quot_q;
	logic [CNT_W-1:0]     cnt_q;

	// Output register
	logic                       out_valid_q;
	logic [PIX_W-1:0]           out_diff_q;
	logic                       out_end_q;
	logic                       out_motion_q;
	logic signed [CHANGE_W-1:0] out_change_q;
	logic [MEAN_W-1:0]          out_mean_q;

	logic [EW-1:0]              fp_ext;
	logic [CW-1:0]              n_eff;
	logic [CW-1:0]              pos_ext;
	logic [CW-1:0]              pos_inc;
	logic [PIX_W-1:0]           old_pix;
	logic [PIX_W-1:0]           diff;
	logic                       last;
	logic [DW-1:0]              product;
	logic                       rem_ge;
	logic [MEAN_W-1:0]          mean_sat;
	logic signed [CHANGE_W:0]   change_full;
	logic signed [CHANGE_W:0]   thresh_ext;

	assign fp_ext = EW'(frame_pixels_q);

	always_comb begin
		if (frame_pixels_q == '0) begin
			n_eff = CW'(1);
		end else if (fp_ext > EW'(MAX_PIXELS)) begin
			n_eff = CW'(MAX_PIXELS);
		end else begin
			n_eff = fp_ext[CW-1:0];
		end
	end

	assign pos_ext = CW'(pos_q);
	assign pos_inc = pos_ext + CW'(1);
	assign last    = (pos_inc >= n_eff);
	assign old_pix = (pos_ext < fill_q) ? rd_q : '0;
	assign diff    = (pix_q >= old_pix) ? (pix_q - old_pix) : (old_pix - pix_q);

	// 100 * sum as 64 + 32 + 4
	assign product = DW'({sum_q, 6'd0}) + DW'({sum_q, 5'd0}) + DW'({sum_q, 2'd0});
	assign rem_ge  = (rem_q >= dsr_q);

	assign mean_sat    = (quot_q > MEAN_MAX) ? MEAN_MAX : quot_q;
	assign change_full = $signed({2'b00, mean_sat}) - $signed({2'b00, prev_mean_q});
	assign thresh_ext  = $signed({threshold_q[THRESH_W-1], threshold_q});

	assign sts.last     = last;
	assign sts.div_last = (cnt_q == '0);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= FRAME_PIXELS_RST;
			threshold_q    <= THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_PIXELS:     frame_pixels_q <= cfg_data;
				CFG_MOTION_THRESHOLD: threshold_q    <= cfg_data[THRESH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Frame store: read on load, write back the new pixel on update
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q <= mem[pos_q];
		end
		if (cmd.update) begin
			mem[pos_q] <= pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			prev_mean_q <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				sum_q <= sum_q + SW'(diff);
				pos_q <= last ? '0 : pos_inc[AW-1:0];
				if (pos_ext == fill_q) begin
					fill_q <= pos_inc;
				end
			end
			if (cmd.mul) begin
				cnt_q <= DIV_START;
			end else if (cmd.div_step && cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.finish) begin
				prev_mean_q <= mean_sat;
				sum_q       <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q <= pixel;
		end
		if (cmd.update) begin
			diff_q <= diff;
			last_q <= last;
		end
		if (cmd.mul) begin
			rem_q  <= product;
			dsr_q  <= DW'({n_eff, {(QUOT_BITS - 1){1'b0}}});
			quot_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_ge) begin
				rem_q <= rem_q - dsr_q;
			end
			quot_q <= {quot_q[QUOT_BITS-2:0], rem_ge};
			dsr_q  <= dsr_q >> 1;
		end
		if (cmd.finish) begin
			mean_q   <= mean_sat;
			change_q <= change_full[CHANGE_W-1:0];
			motion_q <= (change_full >= thresh_ext);
		end
		if (cmd.emit) begin
			out_diff_q   <= diff_q;
			out_end_q    <= last_q;
			out_motion_q <= last_q & motion_q;
			out_change_q <= last_q ? change_q : '0;
			out_mean_q   <= last_q ? mean_q : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign diff_pixel      = out_diff_q;
	assign frame_end       = out_end_q;
	assign motion          = out_motion_q;
	assign mean_change     = out_change_q;
	assign mean_hundredths = out_mean_q;

endmodule

`default_nettype wire

// ----- rtl/core/frame_difference_motion_detector.sv -----
// Top level of the frame-difference motion detector: controller plus datapath.
//
// Usage:
//   Pixels come in on in_valid/pixel and are taken when in_stall is low.
//   Each request gives one result on out_valid with diff_pixel and frame_end;
//   on the last pixel of a frame motion, mean_change and mean_hundredths
//   carry the frame statistics, otherwise they are zero.
//   Configuration writes (index 0 frame_pixels, 1 motion_threshold) use
//   cfg_valid/cfg_ready; cfg_ready is always high. Write only while idle.
// Sequence:
//   An ordinary pixel's old value is read from the frame store into a register
//   (load), the pixel is differenced and written back (update), then it is put
//   into the output register (emit); no new pixel is taken until then. The last
//   pixel of a frame adds a multiply step, 15 divider steps and a finish step
//   before emit, for the one-bit-per-cycle divider for floor(100*sum/pixels).
// Reset:
//   arst_n clears the pixel position, the sum, the previous mean and the
//   store fill count; unwritten store entries read as zero, so no clearing
//   pass is needed.
// Stall:
//   While out_stall is high the result holds; a finished pixel waits in the
//   controller until the output register frees, then new pixels are taken.
`default_nettype none

module frame_difference_motion_detector import fdmd_pkg::*; #(
	parameter int MAX_PIXELS = 2097152
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [PIX_W-1:0]           pixel,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [PIX_W-1:0]           diff_pixel,
	output logic                       frame_end,
	output logic                       motion,
	output logic signed [CHANGE_W-1:0] mean_change,
	output logic [MEAN_W-1:0]          mean_hundredths,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic cfg_we;

	// Registers are always writable
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	fdmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	fdmd_dp #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.pixel           (pixel),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.diff_pixel      (diff_pixel),
		.frame_end       (frame_end),
		.motion          (motion),
		.mean_change     (mean_change),
		.mean_hundredths (mean_hundredths)
	);

endmodule

`default_nettype wire

// ----- rtl/core/fdmd_checker.sv -----
// Port-level checker of the frame-difference motion detector and its bind.
`default_nettype none
`include "assert_macros.svh"

module fdmd_checker import fdmd_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [PIX_W-1:0]           diff_pixel,
	input logic                       frame_end,
	input logic                       motion,
	input logic signed [CHANGE_W-1:0] mean_change,
	input logic [MEAN_W-1:0]          mean_hundredths
);

	// A stalled result holds
	`FDMD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(diff_pixel) && $stable(frame_end) && $stable(mean_change), "stalled result changed")

	// Statistics are zero away from frame end
	`FDMD_ASSERT(a_stats_zero, clk, arst_n, (out_valid && !frame_end) |-> (!motion && mean_change == '0 && mean_hundredths == '0), "statistics set off frame end")

	// Mean stays in range
	`FDMD_ASSERT(a_mean_range, clk, arst_n, out_valid |-> (mean_hundredths <= MEAN_MAX), "mean out of range")

	// One pixel at a time: busy right after an accepted request
	`FDMD_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && !in_stall, in_stall, "request taken while busy")

endmodule

bind frame_difference_motion_detector fdmd_checker u_fdmd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.diff_pixel      (diff_pixel),
	.frame_end       (frame_end),
	.motion          (motion),
	.mean_change     (mean_change),
	.mean_hundredths (mean_hundredths)
);

`default_nettype wire

// ----- bench/fdmd_checker.sv -----
// Checker for the frame-difference motion detector: tracks requests, predicts results, compares.
module fdmd_tb_checker import fdmd_pkg::*; #(
	parameter int MAX_PIXELS = 2097152
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [PIX_W-1:0]           pixel,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [PIX_W-1:0]           diff_pixel,
	input  logic                       frame_end,
	input  logic                       motion,
	input  logic signed [CHANGE_W-1:0] mean_change,
	input  logic [MEAN_W-1:0]          mean_hundredths,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	output int                         pending,
	output int                         fail_count
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [PIX_W-1:0]           diff;
		logic                       last;
		logic                       moved;
		logic signed [CHANGE_W-1:0] change;
		logic [MEAN_W-1:0]          mean;
	} motion_result_t;

	// Shadow of the frame store and running frame statistics.
	logic [PIX_W-1:0]          prior_luma [int unsigned];
	int unsigned               pos_in_frame;
	longint unsigned           frame_diff_total;
	int unsigned               last_mean;
	logic [FRAME_PIXELS_W-1:0] frame_size;
	logic [THRESH_W-1:0]       motion_floor;
	motion_result_t            awaited_results[$];
	motion_result_t            seen;
	motion_result_t            wanted;
	int                        misses;

	function automatic motion_result_t frame_diff_outcome(input logic [PIX_W-1:0] luma);
		int unsigned     frame_len;
		int unsigned     pos;
		logic [PIX_W-1:0] old_luma;
		longint unsigned mean;
		int              change;
		motion_result_t  r;
		frame_len = 32'(frame_size);
		if (frame_len == 0) frame_len = 1;
		if (frame_len > MAX_PIXELS) frame_len = MAX_PIXELS;
		pos = pos_in_frame;
		if (pos >= MAX_PIXELS) pos = 0;
		old_luma = prior_luma.exists(pos) ? prior_luma[pos] : '0;
		r = '0;
		r.diff = (luma >= old_luma) ? luma - old_luma : old_luma - luma;
		prior_luma[pos] = luma;
		frame_diff_total += r.diff;
		r.last = (pos + 1 >= frame_len);
		if (r.last) begin
			mean = frame_diff_total * 100 / frame_len;
			if (mean > MEAN_MAX) mean = MEAN_MAX;
			change = int'(mean) - int'(last_mean);
			r.moved = (change >= int'($signed(motion_floor)));
			r.change = change[CHANGE_W-1:0];
			r.mean = mean[MEAN_W-1:0];
			last_mean = 32'(mean);
			frame_diff_total = 0;
			pos_in_frame = 0;
		end else begin
			pos_in_frame = pos + 1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_luma.delete();
			pos_in_frame = 0;
			frame_diff_total = 0;
			last_mean = 0;
			frame_size = FRAME_PIXELS_RST;
			motion_floor = THRESHOLD_RST;
			awaited_results.delete();
			misses = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRAME_PIXELS: frame_size = cfg_data;
					CFG_MOTION_THRESHOLD: motion_floor = cfg_data[THRESH_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				seen.diff = diff_pixel;
				seen.last = frame_end;
				seen.moved = motion;
				seen.change = mean_change;
				seen.mean = mean_hundredths;
				if (awaited_results.size() == 0) begin
					misses++;
					if (misses <= REPORT_LIMIT)
						$display("unexpected result: diff %0d end %0b motion %0b change %0d mean %0d",
							seen.diff, seen.last, seen.moved, seen.change, seen.mean);
				end else begin
					wanted = awaited_results.pop_front();
					if (seen !== wanted) begin
						misses++;
						if (misses <= REPORT_LIMIT)
							$display("mismatch: expected diff %0d end %0b motion %0b change %0d mean %0d, got diff %0d end %0b motion %0b change %0d mean %0d",
								wanted.diff, wanted.last, wanted.moved, wanted.change, wanted.mean,
								seen.diff, seen.last, seen.moved, seen.change, seen.mean);
					end
				end
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(frame_diff_outcome(pixel));
			pending <= awaited_results.size();
			fail_count <= misses;
		end
	end

endmodule

// ----- bench/frame_difference_motion_detector_test.sv -----
// Testbench top for the frame-difference motion detector: stimulus, flow control and verdict.
module frame_difference_motion_detector_test;
	import fdmd_pkg::*;

	localparam int MAX_PIXELS   = 2097152;
	localparam int RANDOM_ITEMS = 1000;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 40;
	localparam int LONG_HOLD    = 120;
	localparam int HOLD_AFTER   = 300;

	localparam logic [CFG_IDX_W-1:0]      CFG_FIRST_UNMAPPED = 8'd2;
	localparam logic [CFG_IDX_W-1:0]      CFG_LAST_UNMAPPED  = 8'hFF;
	localparam logic [FRAME_PIXELS_W-1:0] SIZE_FIELD_TOP     = 22'h3FFFFF;
	localparam logic [THRESH_W-1:0]       THRESH_LOWEST      = -16'sd25500;
	localparam logic [THRESH_W-1:0]       THRESH_HIGHEST     = 16'sd25500;
	localparam logic [THRESH_W-1:0]       THRESH_WRAP_LOW    = 16'h8000;
	localparam logic [THRESH_W-1:0]       THRESH_WRAP_HIGH   = 16'h7FFF;

	typedef enum {PAT_NOISE, PAT_FLAT, PAT_BAND, PAT_EXTREME} luma_pattern_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [PIX_W-1:0]           pixel;
	logic                       out_valid;
	logic                       out_stall;
	logic [PIX_W-1:0]           diff_pixel;
	logic                       frame_end;
	logic                       motion;
	logic signed [CHANGE_W-1:0] mean_change;
	logic [MEAN_W-1:0]          mean_hundredths;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	int pending;
	int fail_count;
	int sent_items = 0;
	int idle_cycles = 0;
	bit sender_steady = 1'b0;

	always #4 clk = ~clk;

	frame_difference_motion_detector #(.MAX_PIXELS(MAX_PIXELS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.diff_pixel(diff_pixel), .frame_end(frame_end), .motion(motion),
		.mean_change(mean_change), .mean_hundredths(mean_hundredths),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	fdmd_tb_checker #(.MAX_PIXELS(MAX_PIXELS)) u_tb_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.diff_pixel(diff_pixel), .frame_end(frame_end), .motion(motion),
		.mean_change(mean_change), .mean_hundredths(mean_hundredths),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .fail_count(fail_count)
	);

	// Offer one pixel request after a random gap (none while the sender is steady), hold it until taken.
	task automatic send_pixel(input logic [PIX_W-1:0] luma);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= luma;
		do @(posedge clk); while (in_stall);
		sent_items++;
	endtask

	// Drop valid and hold until every predicted result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Drain, then write the selected registers back to back; keep cfg_valid high
	// across consecutive writes so it is raised and lowered only once.
	task automatic load_settings(input bit set_size, input logic [FRAME_PIXELS_W-1:0] size,
			input bit set_floor, input logic [THRESH_W-1:0] floor_val, input bit poke_unmapped);
		logic [CFG_DATA_W-1:0] word;
		drain_results();
		if (set_size) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_FRAME_PIXELS;
			cfg_data <= size;
			do @(posedge clk); while (!cfg_ready);
		end
		if (set_floor) begin
			// Upper data bits are don't-care for the threshold; randomize them.
			word = CFG_DATA_W'($urandom);
			word[THRESH_W-1:0] = floor_val;
			cfg_valid <= 1'b1;
			cfg_index <= CFG_MOTION_THRESHOLD;
			cfg_data <= word;
			do @(posedge clk); while (!cfg_ready);
		end
		if (poke_unmapped) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'($urandom_range(CFG_FIRST_UNMAPPED, CFG_LAST_UNMAPPED));
			cfg_data <= CFG_DATA_W'($urandom);
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Watchdog: end the run if no channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles == IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Result side: random stalls with calm stretches, plus one long hold-off
	// while the sender is still offering so the block backs up into its input.
	initial begin
		int  hold;
		int  taken;
		bit  steady;
		bit  long_hold_done;
		taken = 0;
		steady = 1'b0;
		long_hold_done = 1'b0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 64 == 0) steady = ($urandom_range(0, 3) == 0);
			hold = steady ? 0 : $urandom_range(0, 7);
			if (!long_hold_done && taken >= HOLD_AFTER && in_valid) begin
				hold = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Request side: reset, directed cases, then random phases.
	initial begin
		int                        r;
		int                        count;
		luma_pattern_t             pattern;
		logic [PIX_W-1:0]          base;
		logic [PIX_W-1:0]          luma;
		bit                        set_size;
		bit                        set_floor;
		logic [FRAME_PIXELS_W-1:0] size;
		logic [THRESH_W-1:0]       floor_val;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		pixel <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: two pixels against the all-zero store, mid-frame.
		send_pixel(8'hFF);
		send_pixel(8'h00);
		// Four-pixel frames; the position carries over, so this one ends early.
		load_settings(1'b1, 22'd4, 1'b1, 16'd5, 1'b0);
		send_pixel(8'h80);
		send_pixel(8'h01);
		// Full-swing differences, then an unchanged frame for a drop in the mean.
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h80);
		send_pixel(8'hFE);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h80);
		send_pixel(8'hFE);
		// Zero frame size acts as one pixel; lowest threshold.
		load_settings(1'b1, 22'd0, 1'b1, THRESH_LOWEST, 1'b0);
		send_pixel(8'h55);
		send_pixel(8'hAA);
		// One-pixel frames with thresholds beyond the nominal range, plus stray writes.
		load_settings(1'b1, 22'd1, 1'b1, THRESH_WRAP_HIGH, 1'b1);
		send_pixel(8'h00);
		load_settings(1'b0, '0, 1'b1, THRESH_WRAP_LOW, 1'b1);
		send_pixel(8'hFF);
		// Oversized frame saturates; fill a few positions with bright pixels.
		load_settings(1'b1, SIZE_FIELD_TOP, 1'b1, THRESH_HIGHEST, 1'b0);
		send_pixel(8'hFF);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		load_settings(1'b1, FRAME_PIXELS_W'(MAX_PIXELS), 1'b0, '0, 1'b0);
		send_pixel(8'hFF);
		send_pixel(8'hFF);
		// Shrink below the current position: next pixel ends the frame.
		load_settings(1'b1, 22'd2, 1'b0, '0, 1'b0);
		send_pixel(8'h00);

		// Random phases: mostly small frames, sometimes long or oversized ones
		// that a later phase shrinks mid-frame.
		while (sent_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 19);
			set_size = 1'b1;
			if (r == 0)
				size = '0;
			else if (r <= 12)
				size = FRAME_PIXELS_W'($urandom_range(1, 16));
			else if (r <= 16)
				size = FRAME_PIXELS_W'($urandom_range(17, 300));
			else if (r == 17)
				size = FRAME_PIXELS_W'($urandom_range(MAX_PIXELS - 4, SIZE_FIELD_TOP));
			else
				set_size = 1'b0;

			r = $urandom_range(0, 9);
			set_floor = 1'b1;
			if (r <= 5)
				floor_val = THRESH_W'($urandom_range(0, 800)) - THRESH_W'(400);
			else if (r == 6)
				floor_val = THRESH_W'($urandom);
			else if (r == 7)
				floor_val = THRESH_LOWEST;
			else if (r == 8)
				floor_val = THRESH_HIGHEST;
			else
				set_floor = 1'b0;

			// Keep streaming across the boundary when nothing is rewritten.
			if (set_size || set_floor || $urandom_range(0, 7) == 0)
				load_settings(set_size, size, set_floor, floor_val, $urandom_range(0, 7) == 0);

			sender_steady = ($urandom_range(0, 3) == 0);
			pattern = luma_pattern_t'($urandom_range(0, 3));
			base = PIX_W'($urandom);
			count = $urandom_range(1, 40);
			repeat (count) begin
				case (pattern)
					PAT_NOISE: luma = PIX_W'($urandom);
					PAT_FLAT: luma = base;
					PAT_BAND: luma = PIX_W'((base > 8'd240) ? $urandom_range(240, 255)
						: $urandom_range(base, base + 15));
					default: luma = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				endcase
				send_pixel(luma);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
